// ----- src/fpr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the framed packet receiver.
package fpr_pkg;

	localparam int BYTE_W      = 8;
	localparam int LENGTH_W    = 6;
	localparam int INDEX_W     = 5;
	localparam int CFG_INDEX_W = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_FIRST_SYNC  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_SECOND_SYNC = CFG_INDEX_W'(1);

	localparam logic [BYTE_W-1:0] FIRST_SYNC_RESET  = 8'd170;
	localparam logic [BYTE_W-1:0] SECOND_SYNC_RESET = 8'd175;

	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	typedef enum logic [5:0] {
		PH_SYNC1 = 6'b000001,
		PH_SYNC2 = 6'b000010,
		PH_ID    = 6'b000100,
		PH_LEN   = 6'b001000,
		PH_DATA  = 6'b010000,
		PH_CHK   = 6'b100000
	} phase_t;

endpackage

// ----- src/framed_packet_receiver.sv -----
`timescale 1ns / 1ps
// Framed packet receiver: sync search, header parse, payload buffer and packet replay.
// The parser accepts one input item per cycle outside replay.
// A good checksum byte starts a replay from the payload memory: the replay flag, the read stage
// and the output register lie between that item and the first result; then one result per cycle
// while the output is taken. Input is held off while the replay reads are issued, including
// every cycle in which the output stalls the replay.
// Reset clears the parser and output control; the payload memory is not cleared.
module framed_packet_receiver #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic [fpr_pkg::BYTE_W-1:0]        rx_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fpr_pkg::BYTE_W-1:0]        message_id,
	output logic [fpr_pkg::LENGTH_W-1:0]      payload_length,
	output logic [fpr_pkg::INDEX_W-1:0]       payload_index,
	output logic [fpr_pkg::BYTE_W-1:0]        payload_byte,
	output logic                              last_of_packet,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fpr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [fpr_pkg::BYTE_W-1:0]        cfg_data
);
	import fpr_pkg::*;

	localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam logic [BYTE_W-1:0] MAX_LEN_BYTE = BYTE_W'(MAX_PAYLOAD);

	logic [BYTE_W-1:0] first_sync_q;
	logic [BYTE_W-1:0] second_sync_q;

	phase_t            phase_q;
	logic [BYTE_W-1:0] chk_q;
	logic [BYTE_W-1:0] held_id_q;
	logic [LEN_W-1:0]  held_len_q;
	logic [LEN_W-1:0]  fill_q;

	logic [BYTE_W-1:0] mem [MAX_PAYLOAD];

	logic              emit_q;
	logic [LEN_W-1:0]  rd_ptr_q;

	logic              valid_s1;
	logic [BYTE_W-1:0] rdata_s1;
	logic [BYTE_W-1:0] id_s1;
	logic [LENGTH_W-1:0] len_s1;
	logic [INDEX_W-1:0] idx_s1;
	logic              last_s1;
	logic              empty_s1;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_id_q;
	logic [LENGTH_W-1:0] out_len_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic              in_take;
	logic              out_free;
	logic              move_s1;
	logic              rd_issue;
	logic              rd_last;
	logic              mem_we;
	logic [BYTE_W-1:0] chk_sum;
	logic [LEN_W-1:0]  fill_next;

	assign cfg_ready = 1'b1;
	assign in_ready  = !emit_q;
	assign in_take   = in_valid && in_ready;
	assign chk_sum   = chk_q + rx_byte;
	assign fill_next = fill_q + LEN_W'(1);
	assign mem_we    = in_take && (operation == OP_BYTE) && (phase_q == PH_DATA);

	assign out_free = !out_valid_q || out_ready;
	assign move_s1  = valid_s1 && out_free;
	assign rd_issue = emit_q && (!valid_s1 || move_s1);
	assign rd_last  = (held_len_q == '0) || (rd_ptr_q + LEN_W'(1) == held_len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sync_q  <= FIRST_SYNC_RESET;
			second_sync_q <= SECOND_SYNC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FIRST_SYNC:  first_sync_q  <= cfg_data;
				REG_SECOND_SYNC: second_sync_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SYNC1;
			chk_q      <= '0;
			held_id_q  <= '0;
			held_len_q <= '0;
			fill_q     <= '0;
			emit_q     <= 1'b0;
			rd_ptr_q   <= '0;
		end else begin
			if (rd_issue) begin
				rd_ptr_q <= rd_ptr_q + LEN_W'(1);
				if (rd_last) begin
					emit_q <= 1'b0;
				end
			end
			if (in_take) begin
				if (operation == OP_TIMEOUT) begin
					phase_q <= PH_SYNC1;
				end else begin
					unique case (phase_q)
						PH_SYNC2: begin
							phase_q <= (rx_byte == second_sync_q) ? PH_ID : PH_SYNC1;
							chk_q   <= chk_sum;
						end
						PH_ID: begin
							held_id_q <= rx_byte;
							chk_q     <= chk_sum;
							phase_q   <= PH_LEN;
						end
						PH_LEN: begin
							if (rx_byte <= MAX_LEN_BYTE) begin
								held_len_q <= rx_byte[LEN_W-1:0];
								fill_q     <= '0;
								chk_q      <= chk_sum;
								phase_q    <= (rx_byte != '0) ? PH_DATA : PH_CHK;
							end else begin
								phase_q <= PH_SYNC1;
							end
						end
						PH_DATA: begin
							fill_q <= fill_next;
							chk_q  <= chk_sum;
							if (fill_next >= held_len_q) begin
								phase_q <= PH_CHK;
							end
						end
						PH_CHK: begin
							if (chk_q == rx_byte) begin
								emit_q   <= 1'b1;
								rd_ptr_q <= '0;
							end
							phase_q <= PH_SYNC1;
						end
						default: begin
							phase_q <= (rx_byte == first_sync_q) ? PH_SYNC2 : PH_SYNC1;
							chk_q   <= rx_byte;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[fill_q[AW-1:0]] <= rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rdata_s1 <= mem[rd_ptr_q[AW-1:0]];
			id_s1    <= held_id_q;
			len_s1   <= LENGTH_W'(held_len_q);
			idx_s1   <= INDEX_W'(rd_ptr_q);
			last_s1  <= rd_last;
			empty_s1 <= (held_len_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rd_issue) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_id_q   <= id_s1;
			out_len_q  <= len_s1;
			out_idx_q  <= idx_s1;
			out_byte_q <= empty_s1 ? '0 : rdata_s1;
			out_last_q <= last_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign message_id     = out_id_q;
	assign payload_length = out_len_q;
	assign payload_index  = out_idx_q;
	assign payload_byte   = out_byte_q;
	assign last_of_packet = out_last_q;

	a_no_write_in_replay: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && emit_q))
		else $error("Payload memory written during a replay.");

	a_replay_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(emit_q) |-> $past(in_take && operation == OP_BYTE && phase_q == PH_CHK))
		else $error("Replay started outside a checksum byte.");

	a_replay_end: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_issue && rd_last) |=> !emit_q)
		else $error("Replay continued after its last read.");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(idx_s1) && $stable(last_s1)))
		else $error("Read stage changed while stalled.");

endmodule

// ----- sim/fpr_checker.sv -----
`timescale 1ns / 1ps
// Checker for the framed packet receiver: predicts every packet result and compares what comes out.
module fpr_checker #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            operation,
	input  logic [fpr_pkg::BYTE_W-1:0]      rx_byte,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [fpr_pkg::BYTE_W-1:0]      message_id,
	input  logic [fpr_pkg::LENGTH_W-1:0]    payload_length,
	input  logic [fpr_pkg::INDEX_W-1:0]     payload_index,
	input  logic [fpr_pkg::BYTE_W-1:0]      payload_byte,
	input  logic                            last_of_packet,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [fpr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fpr_pkg::BYTE_W-1:0]      cfg_data,
	output int                              mismatches,
	output int                              outstanding
);
	import fpr_pkg::*;

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	typedef struct packed {
		logic [BYTE_W-1:0]   id;
		logic [LENGTH_W-1:0] len;
		logic [INDEX_W-1:0]  idx;
		logic [BYTE_W-1:0]   data;
		logic                last;
	} packet_beat_t;

	phase_t              parse_phase;
	logic [BYTE_W-1:0]   sync_first;
	logic [BYTE_W-1:0]   sync_second;
	logic [BYTE_W-1:0]   checksum;
	logic [BYTE_W-1:0]   held_id;
	logic [LENGTH_W-1:0] held_len;
	logic [LENGTH_W-1:0] fill_pos;
	logic [BYTE_W-1:0]   payload_mem [MAX_PAYLOAD];
	packet_beat_t        packet_beats [$];
	int                  fails = 0;

	task automatic queue_packet();
		packet_beat_t beat;
		int i;
		if (held_len == 0) begin
			beat = '{held_id, '0, '0, '0, 1'b1};
			packet_beats.push_back(beat);
		end else begin
			for (i = 0; i < held_len; i++) begin
				beat = '{held_id, held_len, INDEX_W'(i), payload_mem[AW'(i)],
					(i + 1 == held_len)};
				packet_beats.push_back(beat);
			end
		end
	endtask

	task automatic parse_rx_item(logic op, logic [BYTE_W-1:0] c);
		if (op == OP_TIMEOUT) begin
			parse_phase = PH_SYNC1;
			return;
		end
		case (parse_phase)
			PH_SYNC2: begin
				parse_phase = (c == sync_second) ? PH_ID : PH_SYNC1;
				checksum += c;
			end
			PH_ID: begin
				held_id = c;
				checksum += c;
				parse_phase = PH_LEN;
			end
			PH_LEN: begin
				if (c <= MAX_PAYLOAD) begin
					held_len = LENGTH_W'(c);
					fill_pos = '0;
					checksum += c;
					parse_phase = (c != 0) ? PH_DATA : PH_CHK;
				end else begin
					parse_phase = PH_SYNC1;
				end
			end
			PH_DATA: begin
				if (fill_pos < MAX_PAYLOAD)
					payload_mem[fill_pos[AW-1:0]] = c;
				fill_pos++;
				checksum += c;
				if (fill_pos >= held_len)
					parse_phase = PH_CHK;
			end
			PH_CHK: begin
				if (checksum == c)
					queue_packet();
				parse_phase = PH_SYNC1;
			end
			default: begin
				parse_phase = (c == sync_first) ? PH_SYNC2 : PH_SYNC1;
				checksum = c;
			end
		endcase
	endtask

	task automatic check_packet_result();
		packet_beat_t got;
		packet_beat_t want;
		got = '{message_id, payload_length, payload_index, payload_byte, last_of_packet};
		if (packet_beats.size() == 0) begin
			fails++;
			if (fails <= 10)
				$display("Unexpected result: id %h len %0d idx %0d byte %h last %b",
					got.id, got.len, got.idx, got.data, got.last);
		end else begin
			want = packet_beats.pop_front();
			if (got.id !== want.id || got.len !== want.len || got.idx !== want.idx ||
					got.data !== want.data || got.last !== want.last) begin
				fails++;
				if (fails <= 10)
					$display("Mismatch: expected id %h len %0d idx %0d byte %h last %b, ",
						want.id, want.len, want.idx, want.data, want.last,
						"got id %h len %0d idx %0d byte %h last %b",
						got.id, got.len, got.idx, got.data, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_phase = PH_SYNC1;
			checksum = '0;
			held_id = '0;
			held_len = '0;
			fill_pos = '0;
			sync_first = FIRST_SYNC_RESET;
			sync_second = SECOND_SYNC_RESET;
			packet_beats.delete();
		end else begin
			if (out_valid && out_ready)
				check_packet_result();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FIRST_SYNC:  sync_first = cfg_data;
					REG_SECOND_SYNC: sync_second = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				parse_rx_item(operation, rx_byte);
		end
		outstanding <= packet_beats.size();
		mismatches <= fails;
	end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the framed packet receiver: reset, frame and noise stimulus, and the verdict.
module tb;
	import fpr_pkg::*;

	localparam int MAX_LEN = 32;
	localparam int LIMIT   = 500000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic                   operation = OP_BYTE;
	logic [BYTE_W-1:0]      rx_byte = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [BYTE_W-1:0]      message_id;
	logic [LENGTH_W-1:0]    payload_length;
	logic [INDEX_W-1:0]     payload_index;
	logic [BYTE_W-1:0]      payload_byte;
	logic                   last_of_packet;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_FIRST_SYNC;
	logic [BYTE_W-1:0]      cfg_data = '0;

	int                mismatches;
	int                outstanding;
	int                cycles = 0;
	int                stall_left = 0;
	int                items_sent = 0;
	bit                calm = 1'b0;
	logic [BYTE_W-1:0] sync_a = FIRST_SYNC_RESET;
	logic [BYTE_W-1:0] sync_b = SECOND_SYNC_RESET;

	always #2 clk = ~clk;

	framed_packet_receiver #(.MAX_PAYLOAD(MAX_LEN)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.message_id(message_id), .payload_length(payload_length),
		.payload_index(payload_index), .payload_byte(payload_byte),
		.last_of_packet(last_of_packet),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	fpr_checker #(.MAX_PAYLOAD(MAX_LEN)) packet_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.message_id(message_id), .payload_length(payload_length),
		.payload_index(payload_index), .payload_byte(payload_byte),
		.last_of_packet(last_of_packet),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// The receiving side stalls in bursts.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_item(logic op, logic [BYTE_W-1:0] b);
		int gap;
		gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// A frame with a random payload; a cut position replaces that byte by a timeout item and ends the frame.
	task automatic send_frame(logic [BYTE_W-1:0] id, int len, bit good_sum, int cut);
		logic [BYTE_W-1:0] bytes_q [$];
		logic [BYTE_W-1:0] sum;
		int i;
		bytes_q.push_back(sync_a);
		bytes_q.push_back(sync_b);
		bytes_q.push_back(id);
		bytes_q.push_back(BYTE_W'(len));
		if (len <= MAX_LEN) begin
			for (i = 0; i < len; i++)
				bytes_q.push_back(BYTE_W'($urandom_range(0, 255)));
			sum = '0;
			foreach (bytes_q[j])
				sum += bytes_q[j];
			bytes_q.push_back(good_sum ? sum : sum + BYTE_W'($urandom_range(1, 255)));
		end
		for (i = 0; i < bytes_q.size(); i++) begin
			if (i == cut) begin
				send_item(OP_TIMEOUT, BYTE_W'($urandom_range(0, 255)));
				return;
			end
			send_item(OP_BYTE, bytes_q[i]);
		end
	endtask

	task automatic run_random(int n);
		int stop;
		int k;
		int len;
		stop = items_sent + n;
		while (items_sent < stop) begin
			k = $urandom_range(0, 9);
			if (k < 7) begin
				k = $urandom_range(0, 19);
				if (k < 14)
					len = $urandom_range(0, 6);
				else if (k < 18)
					len = $urandom_range(7, MAX_LEN - 1);
				else if (k == 18)
					len = MAX_LEN;
				else
					len = $urandom_range(MAX_LEN + 1, 255);
				send_frame(BYTE_W'($urandom_range(0, 255)), len, $urandom_range(0, 7) != 0,
					($urandom_range(0, 11) == 0) ? $urandom_range(0, len + 4) : -1);
			end else if (k < 9) begin
				send_item(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
			end else begin
				send_item(OP_TIMEOUT, BYTE_W'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		repeat (4) @(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_sync_bytes(logic [BYTE_W-1:0] hdr_a, logic [BYTE_W-1:0] hdr_b);
		cfg_valid <= 1'b1;
		cfg_index <= REG_FIRST_SYNC;
		cfg_data <= hdr_a;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_SECOND_SYNC;
		cfg_data <= hdr_b;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sync_a = hdr_a;
		sync_b = hdr_b;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty payload, a repeated first sync byte, timeout, oversize length, one-byte payload, bad checksum.
		send_frame(8'hFF, 0, 1'b1, -1);
		send_item(OP_BYTE, sync_a);
		send_item(OP_BYTE, sync_a);
		send_item(OP_BYTE, sync_b);
		send_item(OP_BYTE, 8'h00);
		send_frame(8'h12, 4, 1'b1, 1);
		send_frame(8'h00, MAX_LEN + 1, 1'b1, -1);
		send_frame(8'h00, 1, 1'b1, -1);
		send_frame(8'h5A, 0, 1'b0, -1);

		run_random(30);
		settle();
		set_sync_bytes(8'h00, 8'hFF);
		run_random(60);
		settle();
		set_sync_bytes(8'hFF, 8'h00);
		run_random(60);
		settle();
		set_sync_bytes(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
		run_random(15);
		calm = 1'b1;
		run_random(30);
		settle();

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- sim.f -----
src/fpr_pkg.sv
src/framed_packet_receiver.sv
sim/fpr_checker.sv
sim/tb.sv
